@@ rtl/mer_pkg.sv @@
// Shared types and constants of the midpoint ellipse rasterizer.
`timescale 1ns / 1ps

package mer_pkg;

   // Decision values wrap modulo 2^48.
   localparam int DEC_W = 48;

   // Control of the shared multiply / add unit.
   typedef struct packed {
      logic mul_en;   // load the product register
      logic sub;      // subtract instead of add
   } alu_op_type;

endpackage

@@ rtl/mer_alu.sv @@
// Shared arithmetic unit: registered multiplier and a wide add/subtract.
`timescale 1ns / 1ps

module mer_alu
   import mer_pkg::*;
#(
   parameter int RADIUS_BITS = 10
) (
   input  logic                   clock,
   input  alu_op_type             op,
   input  logic [DEC_W-1:0]       mul_a,
   input  logic [RADIUS_BITS:0]   mul_b,
   input  logic [DEC_W-1:0]       add_a,
   input  logic [DEC_W-1:0]       add_b,
   output logic [DEC_W-1:0]       prod,
   output logic [DEC_W-1:0]       sum
);

   logic [DEC_W+RADIUS_BITS:0] full_prod;
   logic [DEC_W-1:0]           prod_ff;

   // Keep the low bits only: all decision math is modulo 2^48.
   assign full_prod = mul_a * mul_b;

   always_ff @(posedge clock) begin
      if (op.mul_en) begin
         prod_ff <= full_prod[DEC_W-1:0];
      end
   end

   assign prod = prod_ff;
   assign sum  = op.sub ? (add_a - add_b) : (add_a + add_b);

endmodule

@@ rtl/midpoint_ellipse_rasterizer_unit.sv @@
// Top level of the midpoint ellipse rasterizer: sequencer, state and result register.
`timescale 1ns / 1ps

// Channel  Dir  Ports               Contents
// req      in   req_tvalid/tready   tdata: radius_x, radius_y, center_x, center_y
//                                   tuser: cmd (0 start, 1 step)
// rsp      out  rsp_tvalid/tready   tdata: pixel_x, pixel_y   tlast: last_of_step
//                                   tuser: done_res
//
// A start word is accepted, then runs four multiply/add steps. A step word
// compares in CMP1..CMP3 in region one and runs SW1..SW7 when it switches
// regions; it then emits four pixels and updates in UPD1..UPD3, plus UPD4 when
// both coordinates move; the final step skips the update. All products share
// one multiplier, one per cycle. req_tready is high only while the sequencer is
// idle; a stalled rsp side stretches the emit phase. Reset clears control.

module midpoint_ellipse_rasterizer_unit
   import mer_pkg::*;
#(
   parameter  int RADIUS_BITS = 10,
   localparam int PIX_W       = RADIUS_BITS + 2,
   localparam int REQ_W       = ((4 * RADIUS_BITS + 7) / 8) * 8,
   localparam int RSP_W       = ((2 * PIX_W + 7) / 8) * 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   // radius_x, radius_y, center_x, center_y (from bit 0 up), zero padded
   input  logic [REQ_W-1:0] req_tdata,
   // cmd
   input  logic             req_tuser,
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   // pixel_x, pixel_y (from bit 0 up), zero padded
   output logic [RSP_W-1:0] rsp_tdata,
   output logic             rsp_tlast,
   // done_res
   output logic             rsp_tuser
);

   localparam int RB = RADIUS_BITS;

   typedef enum logic [19:0] {
      ST_IDLE = 20'h00001,
      ST_SQX  = 20'h00002,
      ST_SQY  = 20'h00004,
      ST_INI1 = 20'h00008,
      ST_INI2 = 20'h00010,
      ST_CMP1 = 20'h00020,
      ST_CMP2 = 20'h00040,
      ST_CMP3 = 20'h00080,
      ST_SW1  = 20'h00100,
      ST_SW2  = 20'h00200,
      ST_SW3  = 20'h00400,
      ST_SW4  = 20'h00800,
      ST_SW5  = 20'h01000,
      ST_SW6  = 20'h02000,
      ST_SW7  = 20'h04000,
      ST_EMIT = 20'h08000,
      ST_UPD1 = 20'h10000,
      ST_UPD2 = 20'h20000,
      ST_UPD3 = 20'h40000,
      ST_UPD4 = 20'h80000
   } state_type;

   state_type state_ff, state_in;

   logic [RB-1:0]    cur_x_ff, cur_x_in;
   logic [RB-1:0]    cur_y_ff, cur_y_in;
   logic [DEC_W-1:0] dec_ff, dec_in;
   logic             in_region_two_ff, in_region_two_in;
   logic             active_ff, active_in;
   logic             take_ff, take_in;
   logic [1:0]       emit_cnt_ff, emit_cnt_in;
   logic [RB-1:0]    held_rx_ff, held_rx_in;
   logic [RB-1:0]    held_ry_ff, held_ry_in;
   logic [RB-1:0]    held_cx_ff, held_cx_in;
   logic [RB-1:0]    held_cy_ff, held_cy_in;
   logic [2*RB-1:0]  rx_sq_ff, rx_sq_in;
   logic [2*RB-1:0]  ry_sq_ff, ry_sq_in;
   logic [DEC_W-1:0] p_hold_ff, p_hold_in;

   logic             rsp_valid_ff, rsp_valid_in;
   logic [PIX_W-1:0] rsp_px_ff, rsp_px_in;
   logic [PIX_W-1:0] rsp_py_ff, rsp_py_in;
   logic             rsp_last_ff, rsp_last_in;
   logic             rsp_done_ff, rsp_done_in;

   alu_op_type       alu_op;
   logic [DEC_W-1:0] mul_a, add_a, add_b, prod, sum;
   logic [RB:0]      mul_b;

   logic             req_take, slot_free, step_done, dec_neg, dec_pos;
   logic [RB-1:0]    x_inc, y_dec, ym_abs;
   logic [DEC_W-1:0] rx_sq_ext, ry_sq_ext;
   logic [PIX_W-1:0] cx_ext, cy_ext, x_ext, y_ext;

   mer_alu #(.RADIUS_BITS(RB)) u_alu (
      .clock (clock),
      .op    (alu_op),
      .mul_a (mul_a),
      .mul_b (mul_b),
      .add_a (add_a),
      .add_b (add_b),
      .prod  (prod),
      .sum   (sum)
   );

   assign req_tready = (state_ff == ST_IDLE);
   assign req_take   = req_tvalid && req_tready;
   assign slot_free  = !rsp_valid_ff || rsp_tready;

   // Saturate x at its top code; y never steps below zero.
   assign x_inc     = (cur_x_ff == {RB{1'b1}}) ? cur_x_ff : cur_x_ff + 1'b1;
   assign y_dec     = cur_y_ff - 1'b1;
   // (y-1)^2 equals 1 when y is zero, as with y-1 = -1.
   assign ym_abs    = (cur_y_ff == '0) ? RB'(1) : y_dec;
   assign dec_neg   = dec_ff[DEC_W-1];
   assign dec_pos   = !dec_ff[DEC_W-1] && (dec_ff != '0);
   assign step_done = in_region_two_ff && (cur_y_ff == '0);

   assign rx_sq_ext = DEC_W'(rx_sq_ff);
   assign ry_sq_ext = DEC_W'(ry_sq_ff);
   assign cx_ext    = PIX_W'(held_cx_ff);
   assign cy_ext    = PIX_W'(held_cy_ff);
   assign x_ext     = PIX_W'(cur_x_ff);
   assign y_ext     = PIX_W'(cur_y_ff);

   always_comb begin
      state_in         = state_ff;
      cur_x_in         = cur_x_ff;
      cur_y_in         = cur_y_ff;
      dec_in           = dec_ff;
      in_region_two_in = in_region_two_ff;
      active_in        = active_ff;
      take_in          = take_ff;
      emit_cnt_in      = emit_cnt_ff;
      held_rx_in       = held_rx_ff;
      held_ry_in       = held_ry_ff;
      held_cx_in       = held_cx_ff;
      held_cy_in       = held_cy_ff;
      rx_sq_in         = rx_sq_ff;
      ry_sq_in         = ry_sq_ff;
      p_hold_in        = p_hold_ff;

      rsp_valid_in     = rsp_valid_ff && !rsp_tready;
      rsp_px_in        = rsp_px_ff;
      rsp_py_in        = rsp_py_ff;
      rsp_last_in      = rsp_last_ff;
      rsp_done_in      = rsp_done_ff;

      alu_op           = '{mul_en: 1'b0, sub: 1'b0};
      mul_a            = '0;
      mul_b            = '0;
      add_a            = dec_ff;
      add_b            = '0;

      case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               if (!req_tuser) begin
                  // Start: latch geometry, place the point at (0, ry).
                  held_rx_in       = req_tdata[RB-1:0];
                  held_ry_in       = req_tdata[2*RB-1:RB];
                  held_cx_in       = req_tdata[3*RB-1:2*RB];
                  held_cy_in       = req_tdata[4*RB-1:3*RB];
                  cur_x_in         = '0;
                  cur_y_in         = req_tdata[2*RB-1:RB];
                  in_region_two_in = 1'b0;
                  active_in        = 1'b1;
                  state_in         = ST_SQX;
               end else if (active_ff) begin
                  state_in = in_region_two_ff ? ST_EMIT : ST_CMP1;
               end
            end
         end
         ST_SQX: begin
            alu_op.mul_en = 1'b1;
            mul_a         = DEC_W'(held_rx_ff);
            mul_b         = (RB+1)'(held_rx_ff);
            state_in      = ST_SQY;
         end
         ST_SQY: begin
            rx_sq_in      = prod[2*RB-1:0];
            alu_op.mul_en = 1'b1;
            mul_a         = DEC_W'(held_ry_ff);
            mul_b         = (RB+1)'(held_ry_ff);
            state_in      = ST_INI1;
         end
         ST_INI1: begin
            // d = rx^2 + 4 ry^2, then subtract 4 rx^2 ry.
            ry_sq_in      = prod[2*RB-1:0];
            alu_op.mul_en = 1'b1;
            mul_a         = rx_sq_ext;
            mul_b         = (RB+1)'(held_ry_ff);
            add_a         = rx_sq_ext;
            add_b         = {prod[DEC_W-3:0], 2'b00};
            dec_in        = sum;
            state_in      = ST_INI2;
         end
         ST_INI2: begin
            alu_op.sub = 1'b1;
            add_b      = {prod[DEC_W-3:0], 2'b00};
            dec_in     = sum;
            state_in   = ST_IDLE;
         end
         ST_CMP1: begin
            alu_op.mul_en = 1'b1;
            mul_a         = ry_sq_ext;
            mul_b         = (RB+1)'(cur_x_ff);
            state_in      = ST_CMP2;
         end
         ST_CMP2: begin
            p_hold_in     = prod;
            alu_op.mul_en = 1'b1;
            mul_a         = rx_sq_ext;
            mul_b         = (RB+1)'(cur_y_ff);
            state_in      = ST_CMP3;
         end
         ST_CMP3: begin
            // Leave region one once ry^2 x passes rx^2 y, or on the x axis.
            if ((cur_y_ff == '0) || (p_hold_ff > prod)) begin
               in_region_two_in = 1'b1;
               state_in         = ST_SW1;
            end else begin
               state_in = ST_EMIT;
            end
         end
         ST_SW1: begin
            alu_op.mul_en = 1'b1;
            mul_a         = ry_sq_ext;
            mul_b         = {cur_x_ff, 1'b1};
            state_in      = ST_SW2;
         end
         ST_SW2: begin
            alu_op.mul_en = 1'b1;
            mul_a         = prod;
            mul_b         = {cur_x_ff, 1'b1};
            state_in      = ST_SW3;
         end
         ST_SW3: begin
            // d = ry^2 (2x+1)^2 + 4 rx^2 (y-1)^2 - 4 rx^2 ry^2
            add_a         = '0;
            add_b         = prod;
            dec_in        = sum;
            alu_op.mul_en = 1'b1;
            mul_a         = rx_sq_ext;
            mul_b         = (RB+1)'(ym_abs);
            state_in      = ST_SW4;
         end
         ST_SW4: begin
            alu_op.mul_en = 1'b1;
            mul_a         = prod;
            mul_b         = (RB+1)'(ym_abs);
            state_in      = ST_SW5;
         end
         ST_SW5: begin
            add_b         = {prod[DEC_W-3:0], 2'b00};
            dec_in        = sum;
            alu_op.mul_en = 1'b1;
            mul_a         = rx_sq_ext;
            mul_b         = (RB+1)'(held_ry_ff);
            state_in      = ST_SW6;
         end
         ST_SW6: begin
            alu_op.mul_en = 1'b1;
            mul_a         = prod;
            mul_b         = (RB+1)'(held_ry_ff);
            state_in      = ST_SW7;
         end
         ST_SW7: begin
            alu_op.sub = 1'b1;
            add_b      = {prod[DEC_W-3:0], 2'b00};
            dec_in     = sum;
            state_in   = ST_EMIT;
         end
         ST_EMIT: begin
            // Pixel order: (+x,+y), (-x,+y), (+x,-y), (-x,-y).
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               rsp_px_in    = emit_cnt_ff[0] ? (cx_ext - x_ext) : (cx_ext + x_ext);
               rsp_py_in    = emit_cnt_ff[1] ? (cy_ext - y_ext) : (cy_ext + y_ext);
               rsp_last_in  = (emit_cnt_ff == 2'd3);
               rsp_done_in  = step_done;
               emit_cnt_in  = emit_cnt_ff + 2'd1;
               if (emit_cnt_ff == 2'd3) begin
                  if (step_done) begin
                     active_in = 1'b0;
                     state_in  = ST_IDLE;
                  end else begin
                     state_in = ST_UPD1;
                  end
               end
            end
         end
         ST_UPD1: begin
            if (!in_region_two_ff) begin
               cur_x_in = x_inc;
               take_in  = !dec_neg;
               if (!dec_neg) begin
                  cur_y_in = y_dec;
               end
            end else begin
               cur_y_in = y_dec;
               take_in  = !dec_pos;
               if (!dec_pos) begin
                  cur_x_in = x_inc;
               end
            end
            state_in = ST_UPD2;
         end
         ST_UPD2: begin
            alu_op.mul_en = 1'b1;
            if (!in_region_two_ff) begin
               mul_a = ry_sq_ext;
               mul_b = {cur_x_ff, 1'b1};
            end else begin
               mul_a  = rx_sq_ext;
               mul_b  = (RB+1)'(cur_y_ff);
               add_b  = {rx_sq_ext[DEC_W-3:0], 2'b00};
               dec_in = sum;
            end
            state_in = ST_UPD3;
         end
         ST_UPD3: begin
            if (!in_region_two_ff) begin
               add_b = {prod[DEC_W-3:0], 2'b00};
               mul_a = rx_sq_ext;
               mul_b = (RB+1)'(cur_y_ff);
            end else begin
               alu_op.sub = 1'b1;
               add_b      = {prod[DEC_W-4:0], 3'b000};
               mul_a      = ry_sq_ext;
               mul_b      = (RB+1)'(cur_x_ff);
            end
            dec_in        = sum;
            alu_op.mul_en = take_ff;
            state_in      = take_ff ? ST_UPD4 : ST_IDLE;
         end
         ST_UPD4: begin
            alu_op.sub = !in_region_two_ff;
            add_b      = {prod[DEC_W-4:0], 3'b000};
            dec_in     = sum;
            state_in   = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= ST_IDLE;
         cur_x_ff         <= '0;
         cur_y_ff         <= '0;
         in_region_two_ff <= 1'b0;
         active_ff        <= 1'b0;
         take_ff          <= 1'b0;
         emit_cnt_ff      <= '0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         state_ff         <= state_in;
         cur_x_ff         <= cur_x_in;
         cur_y_ff         <= cur_y_in;
         in_region_two_ff <= in_region_two_in;
         active_ff        <= active_in;
         take_ff          <= take_in;
         emit_cnt_ff      <= emit_cnt_in;
         rsp_valid_ff     <= rsp_valid_in;
      end
   end

   // Payload registers: no reset needed.
   always_ff @(posedge clock) begin
      dec_ff      <= dec_in;
      held_rx_ff  <= held_rx_in;
      held_ry_ff  <= held_ry_in;
      held_cx_ff  <= held_cx_in;
      held_cy_ff  <= held_cy_in;
      rx_sq_ff    <= rx_sq_in;
      ry_sq_ff    <= ry_sq_in;
      p_hold_ff   <= p_hold_in;
      rsp_px_ff   <= rsp_px_in;
      rsp_py_ff   <= rsp_py_in;
      rsp_last_ff <= rsp_last_in;
      rsp_done_ff <= rsp_done_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_W'({rsp_py_ff, rsp_px_ff});
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tuser  = rsp_done_ff;

`ifndef SYNTH
   a_y_bounded: assert property (@(posedge clock) disable iff (reset)
      active_ff |-> (cur_y_ff <= held_ry_ff))
      else $error("current y above the held radius");

   a_x_monotonic: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_UPD2) |-> (cur_x_ff >= $past(cur_x_ff)))
      else $error("x stepped backward");

   a_region_restart: assert property (@(posedge clock) disable iff (reset)
      $fell(in_region_two_ff) |-> $past(req_tvalid && req_tready && !req_tuser))
      else $error("left region two without a start word");

   a_emit_count: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_EMIT) |-> (emit_cnt_ff == 2'd0))
      else $error("pixel counter not parked outside emit");
`endif

endmodule

@@ tb/sv/midpoint_ellipse_rasterizer_unit_tb.sv @@
// Self-checking testbench of the midpoint ellipse rasterizer, with its own pixel predictor.
`timescale 1ns / 1ps

module midpoint_ellipse_rasterizer_unit_tb
   import mer_pkg::*;
();

   localparam int RADIUS_BITS = 10;
   localparam int REQ_W       = ((4 * RADIUS_BITS + 7) / 8) * 8;
   localparam int PIX_W       = RADIUS_BITS + 2;
   localparam int RSP_W       = ((2 * PIX_W + 7) / 8) * 8;

   // req_tuser codes
   localparam logic CMD_START = 1'b0;
   localparam logic CMD_STEP  = 1'b1;

   localparam logic [RADIUS_BITS-1:0] COORD_MAX = {RADIUS_BITS{1'b1}};

   logic             clock;
   logic             reset;
   logic             req_tvalid;
   logic             req_tready;
   // radius_x, radius_y, center_x, center_y (from bit 0 up)
   logic [REQ_W-1:0] req_tdata;
   // cmd
   logic             req_tuser;
   logic             rsp_tvalid;
   logic             rsp_tready;
   // pixel_x, pixel_y (from bit 0 up)
   logic [RSP_W-1:0] rsp_tdata;
   logic             rsp_tlast;
   // done_res
   logic             rsp_tuser;

   midpoint_ellipse_rasterizer_unit #(.RADIUS_BITS(RADIUS_BITS)) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

   // One plotted pixel as it should leave the rsp channel.
   typedef struct packed {
      logic [PIX_W-1:0] px;
      logic [PIX_W-1:0] py;
      logic             last;
      logic             done;
   } pixel_type;

   pixel_type expected_pixels[$];
   int        failures;
   int        traced_words;   // accepted words that the block acts on

   // Predictor copy of the rasterizer state.
   logic [RADIUS_BITS-1:0] pt_x, pt_y;
   logic signed [DEC_W-1:0] dec;
   logic                   region_two;
   logic                   tracing;
   logic [RADIUS_BITS-1:0] geo_rx, geo_ry, geo_cx, geo_cy;
   logic [63:0]            rx_sq, ry_sq;

   // Sender and receiver pacing.
   int sender_steady;     // 1: no gaps between words
   int burst_left;
   int rsp_free;          // 1: rsp side never stalls outside a hold-off
   int pace_left;
   int pace_stall;
   int hold_off_left;     // long rsp hold-off, counted down on the falling edge

   // -----------------------------------------------------------------------
   // Clock: 20 ns period.
   // -----------------------------------------------------------------------
   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Hard stop in case the block hangs.
   initial begin
      #4_000_000;
      $display("end of test: mismatches");
      $finish;
   end

   // -----------------------------------------------------------------------
   // Predictor: advance the shadow state by one accepted word and queue the
   // pixels that the word must produce.
   // -----------------------------------------------------------------------
   function automatic logic [RADIUS_BITS-1:0] bump_x(input logic [RADIUS_BITS-1:0] v);
      // x saturates at the top of its range
      return (v == COORD_MAX) ? v : v + 1'b1;
   endfunction

   task automatic predict_pixels(input logic cmd, input logic [REQ_W-1:0] data);
      logic [63:0]      x, y, d, tx, ym;
      logic             done_now;
      logic [PIX_W-1:0] ox, oy, sx, sy;
      pixel_type        pix;
      if (cmd == CMD_START) begin
         geo_rx     = data[RADIUS_BITS-1:0];
         geo_ry     = data[2*RADIUS_BITS-1:RADIUS_BITS];
         geo_cx     = data[3*RADIUS_BITS-1:2*RADIUS_BITS];
         geo_cy     = data[4*RADIUS_BITS-1:3*RADIUS_BITS];
         rx_sq      = 64'(geo_rx) * 64'(geo_rx);
         ry_sq      = 64'(geo_ry) * 64'(geo_ry);
         pt_x       = '0;
         pt_y       = geo_ry;
         d          = 64'd4 * ry_sq - 64'd4 * rx_sq * 64'(geo_ry) + rx_sq;
         dec        = d[DEC_W-1:0];
         region_two = 1'b0;
         tracing    = 1'b1;
      end else if (tracing) begin
         x = 64'(pt_x);
         y = 64'(pt_y);
         // switch to region two once the slope passes -1, or on the axis
         if (!region_two && (y == 64'd0 || ry_sq * x > rx_sq * y)) begin
            tx         = 64'd2 * x + 64'd1;
            ym         = y - 64'd1;
            region_two = 1'b1;
            d          = ry_sq * tx * tx + 64'd4 * rx_sq * ym * ym - 64'd4 * rx_sq * ry_sq;
            dec        = d[DEC_W-1:0];
         end
         done_now = region_two && (y == 64'd0);
         ox = PIX_W'(geo_cx);
         oy = PIX_W'(geo_cy);
         sx = PIX_W'(pt_x);
         sy = PIX_W'(pt_y);
         pix = '{px: ox + sx, py: oy + sy, last: 1'b0, done: done_now};
         expected_pixels.push_back(pix);
         pix = '{px: ox - sx, py: oy + sy, last: 1'b0, done: done_now};
         expected_pixels.push_back(pix);
         pix = '{px: ox + sx, py: oy - sy, last: 1'b0, done: done_now};
         expected_pixels.push_back(pix);
         pix = '{px: ox - sx, py: oy - sy, last: 1'b1, done: done_now};
         expected_pixels.push_back(pix);

         d = {{(64-DEC_W){dec[DEC_W-1]}}, dec};
         if (!region_two) begin
            pt_x = bump_x(pt_x);
            x    = 64'(pt_x);
            if (dec < 0) begin
               d = d + 64'd8 * ry_sq * x + 64'd4 * ry_sq;
            end else begin
               pt_y = pt_y - 1'b1;
               y    = 64'(pt_y);
               d    = d + 64'd8 * ry_sq * x - 64'd8 * rx_sq * y + 64'd4 * ry_sq;
            end
            dec = d[DEC_W-1:0];
         end else if (done_now) begin
            tracing = 1'b0;
         end else begin
            pt_y = pt_y - 1'b1;
            y    = 64'(pt_y);
            if (dec > 0) begin
               d = d + 64'd4 * rx_sq - 64'd8 * rx_sq * y;
            end else begin
               pt_x = bump_x(pt_x);
               x    = 64'(pt_x);
               d    = d + 64'd8 * ry_sq * x - 64'd8 * rx_sq * y + 64'd4 * rx_sq;
            end
            dec = d[DEC_W-1:0];
         end
      end
   endtask

   // -----------------------------------------------------------------------
   // Sender: offer one word on req, in bursts with random gaps. Inputs move
   // on the falling edge; acceptance is seen on the rising edge.
   // -----------------------------------------------------------------------
   task automatic offer_word(input logic cmd, input logic [REQ_W-1:0] data);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 12);
         gap        = sender_steady ? 0 : $urandom_range(0, 6);
         // drop valid for the gap, one assignment per falling edge
         repeat (gap) begin
            @(negedge clock);
            req_tvalid <= 1'b0;
         end
      end
      burst_left--;
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tdata  <= data;
      req_tuser  <= cmd;
      do @(posedge clock); while (!req_tready);
      // steps while idle are dropped by the block and do not count
      if (cmd == CMD_START || tracing)
         traced_words++;
      predict_pixels(cmd, data);
   endtask

   function automatic logic [REQ_W-1:0] pack_geometry(input int rx, input int ry,
                                                      input int cx, input int cy);
      logic [REQ_W-1:0] w;
      w = '0;
      w[RADIUS_BITS-1:0]               = rx[RADIUS_BITS-1:0];
      w[2*RADIUS_BITS-1:RADIUS_BITS]   = ry[RADIUS_BITS-1:0];
      w[3*RADIUS_BITS-1:2*RADIUS_BITS] = cx[RADIUS_BITS-1:0];
      w[4*RADIUS_BITS-1:3*RADIUS_BITS] = cy[RADIUS_BITS-1:0];
      return w;
   endfunction

   function automatic logic [REQ_W-1:0] random_data();
      logic [63:0] r;
      r = {$urandom, $urandom};
      return r[REQ_W-1:0];
   endfunction

   task automatic start_ellipse(input int rx, input int ry, input int cx, input int cy);
      offer_word(CMD_START, pack_geometry(rx, ry, cx, cy));
   endtask

   // Step words carry random data, which the block must ignore.
   task automatic step_ellipse();
      offer_word(CMD_STEP, random_data());
   endtask

   task automatic run_to_done();
      while (tracing)
         step_ellipse();
   endtask

   // Drop valid and wait until every queued pixel has come out.
   task automatic settle(input int tail);
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (expected_pixels.size() != 0)
         @(posedge clock);
      repeat (tail) @(posedge clock);
   endtask

   // -----------------------------------------------------------------------
   // Receiver: rsp_tready alternates ready and stall runs of random length,
   // or stays high, or is held low for a long counted hold-off.
   // -----------------------------------------------------------------------
   always @(negedge clock) begin
      if (hold_off_left > 0) begin
         hold_off_left = hold_off_left - 1;
         rsp_tready <= 1'b0;
      end else if (rsp_free) begin
         rsp_tready <= 1'b1;
      end else begin
         if (pace_left == 0) begin
            pace_stall = !pace_stall;
            pace_left  = pace_stall ? $urandom_range(1, 8) : $urandom_range(1, 10);
         end else begin
            pace_left = pace_left - 1;
         end
         rsp_tready <= !pace_stall;
      end
   end

   // -----------------------------------------------------------------------
   // Checker: compare each accepted pixel with the oldest expectation.
   // -----------------------------------------------------------------------
   always @(posedge clock) begin : check_pixels
      pixel_type want;
      pixel_type got;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = '{px:   rsp_tdata[PIX_W-1:0],
                 py:   rsp_tdata[2*PIX_W-1:PIX_W],
                 last: rsp_tlast,
                 done: rsp_tuser};
         if (expected_pixels.size() == 0) begin
            failures++;
            $display("%0t: unexpected pixel x=%0d y=%0d last=%0b done=%0b", $realtime,
                     $signed(got.px), $signed(got.py), got.last, got.done);
         end else begin
            want = expected_pixels.pop_front();
            if (got.px !== want.px) begin
               failures++;
               $display("%0t: pixel_x expected %0d actual %0d", $realtime,
                        $signed(want.px), $signed(got.px));
            end
            if (got.py !== want.py) begin
               failures++;
               $display("%0t: pixel_y expected %0d actual %0d", $realtime,
                        $signed(want.py), $signed(got.py));
            end
            if (got.last !== want.last) begin
               failures++;
               $display("%0t: last_of_step expected %0b actual %0b", $realtime,
                        want.last, got.last);
            end
            if (got.done !== want.done) begin
               failures++;
               $display("%0t: done_res expected %0b actual %0b", $realtime,
                        want.done, got.done);
            end
         end
      end
   end

   // -----------------------------------------------------------------------
   // Tests
   // -----------------------------------------------------------------------

   // A step before any start must be dropped without output.
   task automatic test_idle_step();
      step_ellipse();
   endtask

   // radius_y zero: the first step plots only the centre and ends the ellipse;
   // the step after that is dropped.
   task automatic test_flat_ellipse();
      start_ellipse(5, 0, 100, 200);
      step_ellipse();
      step_ellipse();
   endtask

   // radius_x zero with the centre at the origin, so pixels go negative.
   task automatic test_narrow_ellipse();
      start_ellipse(0, 3, 0, 0);
      run_to_done();
   endtask

   // Field extremes: full radii and centres, zero centres, a point ellipse.
   task automatic test_field_extremes();
      start_ellipse(1023, 1023, 1023, 1023);
      repeat (2) step_ellipse();
      start_ellipse(1023, 1, 0, 1023);
      repeat (2) step_ellipse();
      start_ellipse(1, 1023, 1023, 0);
      step_ellipse();
      start_ellipse(0, 0, 0, 0);
      step_ellipse();
   endtask

   // A start in the middle of an ellipse restarts from the new geometry.
   task automatic test_restart_mid_ellipse();
      start_ellipse(6, 4, 512, 512);
      repeat (2) step_ellipse();
      start_ellipse(2, 3, 40, 900);
      run_to_done();
   endtask

   // Hold rsp off for a long stretch while steps keep coming, so the output
   // register fills and req_tready stays low until the hold-off ends.
   task automatic test_backpressure();
      settle(20);
      sender_steady = 1;
      hold_off_left = 300;
      start_ellipse(7, 5, 300, 300);
      run_to_done();
      sender_steady = 0;
   endtask

   // Mostly whole small ellipses with random geometry and pacing; some big
   // ones cut short, some aborted by a new start, and some noise words.
   task automatic test_random_ellipses(input int target);
      int pick;
      int limit;
      int steps;
      while (traced_words < target) begin
         pick          = $urandom_range(0, 9);
         sender_steady = ($urandom_range(0, 3) == 0);
         rsp_free      = ($urandom_range(0, 3) == 0);
         if (pick < 2) begin
            offer_word(logic'($urandom_range(0, 1)), random_data());
         end else if (pick == 2) begin
            start_ellipse($urandom_range(0, 1023), $urandom_range(0, 1023),
                          $urandom_range(0, 1023), $urandom_range(0, 1023));
            repeat ($urandom_range(1, 4)) step_ellipse();
         end else begin
            start_ellipse($urandom_range(0, 12), $urandom_range(0, 12),
                          $urandom_range(0, 1023), $urandom_range(0, 1023));
            limit = ($urandom_range(0, 5) == 0) ? $urandom_range(1, 6) : 1 << 20;
            steps = 0;
            while (tracing && steps < limit) begin
               step_ellipse();
               steps++;
            end
            // occasionally poke the idle block once more
            if (!tracing && $urandom_range(0, 3) == 0)
               step_ellipse();
         end
      end
      rsp_free      = 0;
      sender_steady = 0;
   endtask

   // -----------------------------------------------------------------------
   // Main sequence
   // -----------------------------------------------------------------------
   initial begin
      reset         = 1'b1;
      req_tvalid    = 1'b0;
      req_tdata     = '0;
      req_tuser     = CMD_START;
      rsp_tready    = 1'b0;
      failures      = 0;
      traced_words  = 0;
      sender_steady = 0;
      burst_left    = 0;
      rsp_free      = 0;
      pace_left     = 0;
      pace_stall    = 1;
      hold_off_left = 0;
      pt_x          = '0;
      pt_y          = '0;
      dec           = '0;
      region_two    = 1'b0;
      tracing       = 1'b0;
      geo_rx        = '0;
      geo_ry        = '0;
      geo_cx        = '0;
      geo_cy        = '0;
      rx_sq         = '0;
      ry_sq         = '0;

      // hold reset, then release it on a falling edge
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_idle_step();
      test_flat_ellipse();
      test_narrow_ellipse();
      test_field_extremes();
      test_restart_mid_ellipse();
      test_backpressure();
      test_random_ellipses(310);

      settle(40);
      if (failures == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

endmodule

@@ filelist.f @@
rtl/mer_pkg.sv
rtl/mer_alu.sv
rtl/midpoint_ellipse_rasterizer_unit.sv
tb/sv/midpoint_ellipse_rasterizer_unit_tb.sv
